FILE: design/fulf_pkg.sv
// fulf_pkg: shared types and constants for the first unique letter finder
// no dependencies; compile before the interfaces and modules
package fulf_pkg;

    localparam int LETTER_W = 5;
    localparam int OUT_W    = 11;
    localparam int CNT_W    = 2;

    localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_SAT  = 2'd2;

    localparam logic [OUT_W-1:0] NONE_POS = 11'h7FF;

    typedef struct packed {
        logic upd;
        logic in_alpha;
        logic scan;
        logic clear;
    } t_fulf_ctl;

endpackage

FILE: design/fulf_in_if.sv
// fulf_in_if: input channel, one letter item per handshake
// depends on fulf_pkg
interface fulf_in_if import fulf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                last;

    modport source (output valid, output letter, output last, input ready);
    modport sink   (input valid, input letter, input last, output ready);
endinterface

FILE: design/fulf_out_if.sv
// fulf_out_if: result channel, one item per string
// depends on fulf_pkg
interface fulf_out_if import fulf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] unique_position;
    logic                    too_long;

    modport source (output valid, output unique_position, output too_long, input ready);
    modport sink   (input valid, input unique_position, input too_long, output ready);
endinterface

FILE: design/first_unique_letter_finder_top.sv
// first_unique_letter_finder_top: string in, position of first unique letter out
// depends on fulf_pkg, fulf_in_if, fulf_out_if and fulf_table
// Letters are taken one per cycle while a string is being counted; each letter
// does a read-modify-write of its entry in the letter table, with forwarding
// between neighbouring letters. After the item that carries last, the input
// stalls through a drain step for the final table write, a scan step that
// reads each alphabet entry through the single read port, a finish step for
// the last compare and a load step into the result register, after which the
// next string may start while the result waits to be taken. If the result of
// the previous string has not been taken yet, the load step and so the stall
// last until it is. Letters past MAX_LEN share position MAX_LEN - 1 and set
// too_long.
module first_unique_letter_finder_top import fulf_pkg::*; #(
    parameter int MAX_LEN       = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fulf_in_if.sink    i_letter,
    fulf_out_if.source o_result
);

    localparam int ADDR_W = $clog2(ALPHABET_SIZE);
    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int PCNT_W = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_COUNT,
        S_DRAIN,
        S_SCAN,
        S_FINISH,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [PCNT_W-1:0] r_pos_cnt;
    logic              r_ovf;
    logic [ADDR_W-1:0] r_scan_addr;
    logic              r_found;
    logic [POS_W-1:0]  r_best;
    logic              r_out_vld;
    logic [OUT_W-1:0]  r_out_pos;
    logic              r_out_long;

    logic              acc;
    logic              at_limit;
    logic [POS_W-1:0]  pos;
    logic [ADDR_W-1:0] addr;
    logic              out_free;
    logic              out_load;
    t_fulf_ctl         ctl;
    logic              hit;
    logic [POS_W-1:0]  hit_pos;

    assign i_letter.ready = (r_state == S_COUNT);
    assign acc            = i_letter.valid && i_letter.ready;
    assign at_limit       = (r_pos_cnt >= PCNT_W'(MAX_LEN));
    assign pos            = at_limit ? POS_W'(MAX_LEN - 1) : POS_W'(r_pos_cnt);
    assign addr           = (r_state == S_SCAN) ? r_scan_addr : ADDR_W'(i_letter.letter);
    assign out_free       = !r_out_vld || o_result.ready;
    assign out_load       = (r_state == S_OUT) && out_free;

    always_comb begin
        ctl.upd      = acc;
        ctl.in_alpha = (int'(i_letter.letter) < ALPHABET_SIZE);
        ctl.scan     = (r_state == S_SCAN);
        ctl.clear    = out_load;
    end

    fulf_table #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ADDR_W        (ADDR_W),
        .POS_W         (POS_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_addr    (addr),
        .i_pos     (pos),
        .o_hit     (hit),
        .o_hit_pos (hit_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COUNT;
            r_pos_cnt   <= '0;
            r_ovf       <= 1'b0;
            r_scan_addr <= '0;
            r_found     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (acc) begin
                if (at_limit) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_pos_cnt <= r_pos_cnt + PCNT_W'(1);
                end
            end
            if (hit && (!r_found || (hit_pos < r_best))) begin
                r_found <= 1'b1;
                r_best  <= hit_pos;
            end
            if (r_out_vld && o_result.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_COUNT: begin
                    if (acc && i_letter.last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_scan_addr <= '0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_scan_addr == ADDR_W'(ALPHABET_SIZE - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_scan_addr <= r_scan_addr + ADDR_W'(1);
                    end
                end
                S_FINISH: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_pos  <= r_found ? OUT_W'(r_best) : NONE_POS;
                        r_out_long <= r_ovf;
                        r_found    <= 1'b0;
                        r_pos_cnt  <= '0;
                        r_ovf      <= 1'b0;
                        r_state    <= S_COUNT;
                    end
                end
                default: begin
                    r_state <= S_COUNT;
                end
            endcase
        end
    end

    assign o_result.valid           = r_out_vld;
    assign o_result.unique_position = r_out_pos;
    assign o_result.too_long        = r_out_long;

`ifndef ASSERT_OFF
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_letter.last) |=> !i_letter.ready)
        else $error("input still ready after last letter");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_OUT))
        else $error("result raised outside the load step");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_cnt <= PCNT_W'(MAX_LEN))
        else $error("position counter past limit");

    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> at_limit)
        else $error("overflow flag set below limit");

    a_no_hit_counting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT) |-> !hit)
        else $error("scan hit while counting");
`endif

endmodule

FILE: design/fulf_table.sv
// fulf_table: per-letter count and first position table with read-modify-write
// depends on fulf_pkg; one synchronous memory plus per-entry valid bits
module fulf_table import fulf_pkg::*; #(
    parameter int ALPHABET_SIZE = 26,
    parameter int ADDR_W        = 5,
    parameter int POS_W         = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fulf_ctl         i_ctl,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [POS_W-1:0]  i_pos,
    output logic              o_hit,
    output logic [POS_W-1:0]  o_hit_pos
);

    localparam int ENT_W = CNT_W + POS_W;

    logic [ENT_W-1:0]         r_mem [ALPHABET_SIZE];
    logic [ENT_W-1:0]         r_q;
    logic [ALPHABET_SIZE-1:0] r_vld_bits;

    logic              r_s1_vld;
    logic              r_s1_alpha;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [POS_W-1:0]  r_s1_pos;

    logic              r_fw_vld;
    logic [ADDR_W-1:0] r_fw_addr;
    logic [ENT_W-1:0]  r_fw_data;

    logic              r_sc_vld;
    logic [ADDR_W-1:0] r_sc_addr;

    logic [ENT_W-1:0] cur;
    logic [CNT_W-1:0] cur_cnt;
    logic [POS_W-1:0] cur_pos;
    logic [CNT_W-1:0] n_cnt;
    logic [POS_W-1:0] n_pos;
    logic             wr_en;

    // current entry: forwarded write, stored value, or empty
    always_comb begin
        if (r_fw_vld && (r_fw_addr == r_s1_addr)) begin
            cur = r_fw_data;
        end else if (r_vld_bits[r_s1_addr]) begin
            cur = r_q;
        end else begin
            cur = '0;
        end
        cur_cnt = cur[ENT_W-1:POS_W];
        cur_pos = cur[POS_W-1:0];
        n_cnt   = (cur_cnt < CNT_SAT) ? cur_cnt + CNT_ONE : cur_cnt;
        n_pos   = (cur_cnt == CNT_ZERO) ? r_s1_pos : cur_pos;
        wr_en   = r_s1_vld && r_s1_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_addr] <= {n_cnt, n_pos};
        end
        r_q <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1_alpha <= i_ctl.in_alpha;
        r_s1_addr  <= i_addr;
        r_s1_pos   <= i_pos;
        r_fw_addr  <= r_s1_addr;
        r_fw_data  <= {n_cnt, n_pos};
        r_sc_addr  <= i_addr;
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_fw_vld   <= 1'b0;
            r_sc_vld   <= 1'b0;
            r_vld_bits <= '0;
        end else begin
            r_s1_vld <= i_ctl.upd;
            r_fw_vld <= wr_en;
            r_sc_vld <= i_ctl.scan;
            if (i_ctl.clear) begin
                r_vld_bits <= '0;
            end else if (wr_en) begin
                r_vld_bits[r_s1_addr] <= 1'b1;
            end
        end
    end

    assign o_hit     = r_sc_vld && r_vld_bits[r_sc_addr] && (r_q[ENT_W-1:POS_W] == CNT_ONE);
    assign o_hit_pos = r_q[POS_W-1:0];

endmodule
